// ===== src/postfix_stack_calculator_macros.svh =====
// Assertion macros used by the checker file psc_checker.sv.
`ifndef POSTFIX_STACK_CALCULATOR_MACROS_SVH
`define POSTFIX_STACK_CALCULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("postfix_stack_calculator: check failed");

// Next-cycle implication, disabled while reset is low.
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("postfix_stack_calculator: check failed");

`endif

// ===== src/psc_pkg.sv =====
package psc_pkg;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_NEG    = 3'd5,
    OP_ANSWER = 3'd6,
    OP_IGNORE = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ABS_R,
    S_DIV,
    S_MUL,
    S_FIX,
    S_RESULT
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] number;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [4:0]         depth;
    status_t            status;
    logic               answer_valid;
  } out_item_t;

endpackage

// ===== src/psc_addsub.sv =====
module psc_addsub #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] sum
);

  // a - b is a + ~b + 1
  assign sum = a + (b ^ {WIDTH{sub}}) + WIDTH'(sub);

endmodule

// ===== src/postfix_stack_calculator.sv =====
// Postfix stack calculator.
// in_*: one token per transfer (operation, number). out_*: one result per token
// (top of stack or popped answer, depth, status, answer_valid).
// Tokens are handled one at a time; in_ready is high only while the sequencer
// is idle, and it stays high while a finished result waits on out_ready.
// Push, add, sub, negate, take answer and ignore pass from S_EXEC to S_RESULT;
// multiply runs S_MUL (shift-add, one multiplier bit a cycle); divide runs
// S_ABS_R, S_DIV (restoring, one quotient bit a cycle) and S_FIX for operand
// and sign fix-up steps. All arithmetic runs through one shared
// adder/subtractor.
// The top of stack sits in a register; the entries below it are in a memory
// with one write and one registered read port.
// Faulted tokens (underflow, overflow, divide by zero) leave the stack as is
// and report the fault in status.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result; memory is not cleared, and stale entries never reach a result.
// When the receiver stalls, the result is held on out_data with out_valid high;
// one further token may be accepted and is finished up to its result, which
// then waits until the held result transfers.
module postfix_stack_calculator import psc_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int BW = $clog2(DATA_WIDTH);

  state_t          state_r, state_nxt;
  op_t             op_r, op_nxt;
  status_t         status_r, status_nxt;
  logic            ans_r, ans_nxt;
  logic            neg_r, neg_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [DW-1:0]   top_r, top_nxt;
  logic [DW-1:0]   opa_r, opa_nxt;
  logic [DW-1:0]   opb_r, opb_nxt;
  logic [DW:0]     acc_r, acc_nxt;
  logic [BW-1:0]   bitcnt_r, bitcnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  logic [DW-1:0]   mem [STACK_DEPTH];
  logic [DW-1:0]   rd_data_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;

  logic [DW:0]     alu_a, alu_b, alu_sum;
  logic            alu_sub;

  logic [CW-1:0]   cnt_m1, cnt_m2;
  logic [DW+31:0]  num_wide;
  logic [DW-1:0]   res_top;
  logic [DW+31:0]  top_wide;
  logic [CW+4:0]   depth_wide;
  logic            last_bit;
  logic [DW:0]     div_shift;

  psc_addsub #(.WIDTH(DW + 1)) u_addsub (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign cnt_m1     = count_r - CW'(1);
  assign cnt_m2     = count_r - CW'(2);
  assign mem_waddr  = cnt_m1[AW-1:0];
  assign mem_raddr  = cnt_m2[AW-1:0];
  assign num_wide   = {{DW{in_data.number[31]}}, in_data.number};
  assign res_top    = ans_r ? opa_r : ((count_r == '0) ? '0 : top_r);
  assign top_wide   = {32'b0, res_top};
  assign depth_wide = {5'b0, count_r};
  assign last_bit   = (bitcnt_r == BW'(DW - 1));
  assign div_shift  = {acc_r[DW-1:0], opa_r[DW-1]};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Stack body: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= top_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    status_r <= status_nxt;
    ans_r    <= ans_nxt;
    neg_r    <= neg_nxt;
    top_r    <= top_nxt;
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    acc_r    <= acc_nxt;
    bitcnt_r <= bitcnt_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    status_nxt    = status_r;
    ans_nxt       = ans_r;
    neg_nxt       = neg_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    acc_nxt       = acc_r;
    bitcnt_nxt    = bitcnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // fetch the entry below the top for binary ops and pops
          mem_re     = 1'b1;
          op_nxt     = in_data.operation;
          opa_nxt    = num_wide[DW-1:0];
          status_nxt = ST_OK;
          ans_nxt    = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_RESULT;
        unique case (op_r)
          OP_PUSH: begin
            if (count_r == CW'(STACK_DEPTH)) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              mem_we    = (count_r != '0);
              top_nxt   = opa_r;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_ADD, OP_SUB: begin
            if (count_r < CW'(2)) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              alu_a     = {1'b0, rd_data_r};
              alu_b     = {1'b0, top_r};
              alu_sub   = (op_r == OP_SUB);
              top_nxt   = alu_sum[DW-1:0];
              count_nxt = cnt_m1;
            end
          end
          OP_MUL: begin
            if (count_r < CW'(2)) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              opa_nxt    = rd_data_r;
              opb_nxt    = top_r;
              acc_nxt    = '0;
              bitcnt_nxt = '0;
              state_nxt  = S_MUL;
            end
          end
          OP_DIV: begin
            if (count_r < CW'(2)) begin
              status_nxt = ST_UNDERFLOW;
            end else if (top_r == '0) begin
              status_nxt = ST_DIV_ZERO;
            end else begin
              // magnitude of the left operand
              alu_b     = {1'b0, rd_data_r};
              alu_sub   = rd_data_r[DW-1];
              opa_nxt   = alu_sum[DW-1:0];
              opb_nxt   = top_r;
              neg_nxt   = rd_data_r[DW-1] ^ top_r[DW-1];
              state_nxt = S_ABS_R;
            end
          end
          OP_NEG: begin
            if (count_r == '0) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              alu_b   = {1'b0, top_r};
              alu_sub = 1'b1;
              top_nxt = alu_sum[DW-1:0];
            end
          end
          OP_ANSWER: begin
            if (count_r == '0) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              // hold the popped value, refill top from the memory read
              opa_nxt   = top_r;
              top_nxt   = rd_data_r;
              count_nxt = cnt_m1;
              ans_nxt   = 1'b1;
            end
          end
          OP_IGNORE: begin
          end
        endcase
      end

      S_ABS_R: begin
        alu_b      = {1'b0, opb_r};
        alu_sub    = opb_r[DW-1];
        opb_nxt    = alu_sum[DW-1:0];
        acc_nxt    = '0;
        bitcnt_nxt = '0;
        state_nxt  = S_DIV;
      end

      S_DIV: begin
        // restoring step: keep the difference when it does not go negative
        alu_a      = div_shift;
        alu_b      = {1'b0, opb_r};
        alu_sub    = 1'b1;
        acc_nxt    = alu_sum[DW] ? div_shift : alu_sum;
        opa_nxt    = {opa_r[DW-2:0], ~alu_sum[DW]};
        bitcnt_nxt = bitcnt_r + BW'(1);
        if (last_bit) begin
          state_nxt = S_FIX;
        end
      end

      S_MUL: begin
        alu_a      = acc_r;
        alu_b      = opb_r[0] ? {1'b0, opa_r} : '0;
        acc_nxt    = {1'b0, alu_sum[DW-1:0]};
        opa_nxt    = opa_r << 1;
        opb_nxt    = opb_r >> 1;
        bitcnt_nxt = bitcnt_r + BW'(1);
        if (last_bit) begin
          top_nxt   = alu_sum[DW-1:0];
          count_nxt = cnt_m1;
          state_nxt = S_RESULT;
        end
      end

      S_FIX: begin
        alu_b     = {1'b0, opa_r};
        alu_sub   = neg_r;
        top_nxt   = alu_sum[DW-1:0];
        count_nxt = cnt_m1;
        state_nxt = S_RESULT;
      end

      S_RESULT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_nxt.top_value    = top_wide[31:0];
          out_nxt.depth        = depth_wide[4:0];
          out_nxt.status       = status_r;
          out_nxt.answer_valid = ans_r;
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/psc_checker.sv =====
`include "postfix_stack_calculator_macros.svh"

module psc_checker import psc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic in_xfer;
  logic underflow_seen;
  logic answer_seen;
  logic in_payload_known;

  assign in_xfer          = in_valid && in_ready;
  assign underflow_seen   = out_valid && (out_data.status == ST_UNDERFLOW);
  assign answer_seen      = out_valid && out_data.answer_valid;
  assign in_payload_known = (in_data.operation == in_data.operation);

  // stalled result holds
  `PSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // one token at a time: busy right after a transfer
  `PSC_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_xfer && in_payload_known, !in_ready)

  // a popped answer never comes with a fault
  `PSC_ASSERT_NOW(a_answer_ok, clk, rst_n, answer_seen, out_data.status == ST_OK)

  // underflow only happens with fewer than two entries
  `PSC_ASSERT_NOW(a_underflow_depth, clk, rst_n, underflow_seen,
    (out_data.depth == 5'd0) || (out_data.depth == 5'd1))

endmodule

bind postfix_stack_calculator psc_checker u_psc_checker (.*);

// ===== dv/psc_result_checker.sv =====
module psc_result_checker import psc_pkg::*; #(
  parameter int STACK_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        failures,
  output int        owed
);

  logic [31:0] stack_copy [STACK_SLOTS];
  int          stack_fill;
  out_item_t   token_reports[$];
  out_item_t   oldest;
  int          fault_count;

  initial begin
    failures    = 0;
    owed        = 0;
    fault_count = 0;
    stack_fill  = 0;
  end

  // Apply one token to the shadow stack and return the report it should produce.
  function automatic out_item_t eval_rpn_token(in_item_t tok);
    logic [31:0] lhs, rhs, val, mag_l, mag_r, quo;
    out_item_t   rep;
    rep              = '0;
    rep.status       = ST_OK;
    rep.answer_valid = 1'b0;
    case (tok.operation)
      OP_PUSH: begin
        if (stack_fill >= STACK_SLOTS) begin
          rep.status = ST_OVERFLOW;
        end else begin
          stack_copy[stack_fill] = tok.number;
          stack_fill++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (stack_fill < 2) begin
          rep.status = ST_UNDERFLOW;
        end else begin
          rhs = stack_copy[stack_fill - 1];
          lhs = stack_copy[stack_fill - 2];
          if (tok.operation == OP_DIV && rhs == 32'd0) begin
            rep.status = ST_DIV_ZERO;
          end else begin
            case (tok.operation)
              OP_ADD:  val = lhs + rhs;
              OP_SUB:  val = lhs - rhs;
              OP_MUL:  val = lhs * rhs;
              default: begin
                // truncate toward zero on magnitudes, then fix the sign
                mag_l = lhs[31] ? -lhs : lhs;
                mag_r = rhs[31] ? -rhs : rhs;
                quo   = mag_l / mag_r;
                val   = (lhs[31] ^ rhs[31]) ? -quo : quo;
              end
            endcase
            stack_fill--;
            stack_copy[stack_fill - 1] = val;
          end
        end
      end
      OP_NEG: begin
        if (stack_fill < 1) rep.status = ST_UNDERFLOW;
        else stack_copy[stack_fill - 1] = -stack_copy[stack_fill - 1];
      end
      OP_ANSWER: begin
        if (stack_fill < 1) begin
          rep.status = ST_UNDERFLOW;
        end else begin
          stack_fill--;
          rep.top_value    = stack_copy[stack_fill];
          rep.answer_valid = 1'b1;
        end
      end
      default: ;
    endcase
    if (!rep.answer_valid && stack_fill > 0) rep.top_value = stack_copy[stack_fill - 1];
    rep.depth = 5'(stack_fill);
    return rep;
  endfunction

  task automatic check_field(string label, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want_v, got_v);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stack_fill = 0;
      token_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (token_reports.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding, got %p", $time, out_data);
          fault_count++;
        end else begin
          oldest = token_reports.pop_front();
          check_field("top_value", oldest.top_value, out_data.top_value);
          check_field("depth", 32'(oldest.depth), 32'(out_data.depth));
          check_field("status", 32'(oldest.status), 32'(out_data.status));
          check_field("answer_valid", 32'(oldest.answer_valid), 32'(out_data.answer_valid));
        end
      end
      if (in_valid && in_ready) token_reports.push_back(eval_rpn_token(in_data));
    end
    owed     <= token_reports.size();
    failures <= fault_count;
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  import psc_pkg::*;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      out_ready = 1'b0;
  in_item_t  in_data = '0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;
  int        failures;
  int        owed;

  int send_idle = 23;
  int recv_idle = 88;
  int tokens_sent = 0;
  int quiet_cycles = 0;

  postfix_stack_calculator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  psc_result_checker u_result_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .failures (failures),
    .owed     (owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one token and hold it until the transfer happens.
  task automatic send_token(op_t op, logic signed [31:0] num);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, number: num};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_IGNORE) tokens_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_number();
    case ($urandom_range(7))
      0, 1, 2: return $urandom;
      3, 4:    return $signed($urandom_range(16)) - 8;
      5:       return 0;
      default: begin
        case ($urandom_range(3))
          0:       return INT_MIN;
          1:       return INT_MAX;
          2:       return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // Post-order token stream for a random expression tree, then pop its answer.
  task automatic send_expression(int leaves);
    int held;
    int left;
    held = 0;
    left = leaves;
    while (left > 0 || held > 1) begin
      if (left > 0 && (held < 2 || $urandom_range(2) != 0)) begin
        send_token(OP_PUSH, pick_number());
        held++;
        left--;
      end else begin
        send_token(op_t'(3'($urandom_range(OP_DIV, OP_ADD))), $urandom);
        held--;
      end
      if (held > 0 && $urandom_range(9) == 0) send_token(OP_NEG, $urandom);
      if ($urandom_range(19) == 0) send_token(OP_IGNORE, $urandom);
    end
    send_token(OP_ANSWER, $urandom);
  endtask

  task automatic run_random(int goal);
    int pick;
    while (tokens_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_expression($urandom_range(1, 8));
      end else if (pick < 78) begin
        send_expression($urandom_range(9, 16));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 18)) send_token(OP_PUSH, pick_number());
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 17)) send_token(OP_ANSWER, $urandom);
      end else begin
        repeat ($urandom_range(1, 6)) send_token(op_t'(3'($urandom_range(7))), pick_number());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty and single-entry faults, wraps, most negative by minus one, divide by zero
    send_token(OP_ANSWER, 0);
    send_token(OP_NEG, INT_MIN);
    send_token(OP_ADD, INT_MAX);
    send_token(OP_PUSH, INT_MAX);
    send_token(OP_SUB, 0);
    send_token(OP_PUSH, 1);
    send_token(OP_ADD, 0);
    send_token(OP_PUSH, -1);
    send_token(OP_DIV, 0);
    send_token(OP_PUSH, 0);
    send_token(OP_DIV, 0);
    send_token(OP_IGNORE, 32'hFFFF_FFFF);
    send_token(OP_ANSWER, 0);
    send_token(OP_NEG, 0);
    send_token(OP_PUSH, -7);
    send_token(OP_PUSH, 2);
    send_token(OP_DIV, 0);
    send_token(OP_MUL, 0);
    send_token(OP_PUSH, INT_MIN);
    send_token(OP_SUB, 0);
    send_token(OP_ANSWER, 0);
    send_token(OP_ANSWER, 0);
    wait_for_results();

    run_random(570);
    wait_for_results();
    send_idle = 88;
    recv_idle = 23;
    run_random(1140);
    wait_for_results();
    send_idle = 0;
    recv_idle = 0;
    run_random(1700);
    wait_for_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
